// ===== hw/rtl/bda_pkg.sv =====
package bda_pkg;

	// Fixed field widths
	localparam int VALUE_W = 27;
	localparam int CHAR_W = 6;
	localparam int DIGIT_W = 4;

	localparam int NUM_DIGITS_DEF = 8;

	// ASCII codes of the digits '0' and '9'
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

	// Divide by ten: q = (v * RECIP_TEN) >> RECIP_SH, exact for any v below 2^32
	localparam int RECIP_W = 32;
	localparam int RECIP_SH = 35;
	localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

	// Control that travels with each word down the pipeline
	typedef struct packed {
		logic vld;
		logic ovf;
	} bda_ctl_t;

	// Largest number that fits in n decimal digits
	function automatic logic [63:0] max_decimal(input int n);
		logic [63:0] m;
		m = 64'd1;
		for (int i = 0; i < n; i++) begin
			m = m * 64'd10;
		end
		return m - 64'd1;
	endfunction

endpackage

// ===== hw/rtl/bda_clamp.sv =====
module bda_clamp
	import bda_pkg::*;
#(
	parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               start,
	input  logic [VALUE_W-1:0] value,
	output bda_ctl_t           ctl_s1,
	output logic [VALUE_W-1:0] val_s1
);

	localparam logic [63:0] LIMIT = max_decimal(NUM_DIGITS);

	logic ovf;

	assign ovf = (64'(value) > LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.vld <= start;
			ctl_s1.ovf <= ovf;
		end
	end

	// Saturate to all nines
	always_ff @(posedge clk) begin
		if (adv) begin
			val_s1 <= ovf ? LIMIT[VALUE_W-1:0] : value;
		end
	end

endmodule

// ===== hw/rtl/bda_digit_stage.sv =====
module bda_digit_stage
	import bda_pkg::*;
#(
	parameter int NUM_DIGITS = NUM_DIGITS_DEF,
	parameter int IDX_W = 3,
	parameter int K = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  bda_ctl_t                             ctl_i,
	input  logic [VALUE_W-1:0]                   rest_i,
	input  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   digs_i,
	input  logic [IDX_W-1:0]                     msd_i,
	output bda_ctl_t                             ctl_s,
	output logic [VALUE_W-1:0]                   rest_s,
	output logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   digs_s,
	output logic [IDX_W-1:0]                     msd_s
);

	localparam int PROD_W = VALUE_W + RECIP_W;

	logic [PROD_W-1:0]  prod;
	logic [VALUE_W-1:0] quo;
	logic [VALUE_W-1:0] quo_x10;
	logic [DIGIT_W-1:0] dig;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digs_nxt;

	// Divide by ten through the reciprocal, then recover the remainder
	assign prod    = PROD_W'(rest_i) * PROD_W'(RECIP_TEN);
	assign quo     = VALUE_W'(prod[PROD_W-1:RECIP_SH]);
	assign quo_x10 = (quo << 3) + (quo << 1);
	assign dig     = DIGIT_W'(rest_i - quo_x10);

	// Drop this stage's digit into its slot
	always_comb begin
		digs_nxt    = digs_i;
		digs_nxt[K] = dig;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s <= '0;
		end else if (adv) begin
			ctl_s <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rest_s <= quo;
			digs_s <= digs_nxt;
			// Track the most significant nonzero digit seen so far
			msd_s  <= (dig != '0) ? IDX_W'(K) : msd_i;
		end
	end

endmodule

// ===== hw/rtl/bda_serializer.sv =====
module bda_serializer
	import bda_pkg::*;
#(
	parameter int NUM_DIGITS = NUM_DIGITS_DEF,
	parameter int IDX_W = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  bda_ctl_t                           ctl_i,
	input  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digs_i,
	input  logic [IDX_W-1:0]                   msd_i,
	output logic                               rdy,
	output logic                               strobe,
	output logic [CHAR_W-1:0]                  char_code,
	output logic                               last,
	output logic                               overflow
);

	logic                               act_q;
	logic [IDX_W-1:0]                   idx_q;
	logic                               ovf_q;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digs_q;

	// Free when idle or sending the units digit
	assign rdy = !act_q || (idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			act_q <= 1'b1;
			idx_q <= msd_i;
		end else if (act_q && (idx_q == '0)) begin
			act_q <= 1'b0;
		end else if (act_q) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digs_q <= digs_i;
			ovf_q  <= ctl_i.ovf;
		end
	end

	assign strobe    = act_q;
	assign char_code = ASCII_ZERO + CHAR_W'(digs_q[idx_q]);
	assign last      = (idx_q == '0);
	assign overflow  = ovf_q;

endmodule

// ===== hw/rtl/binary_to_decimal_ascii.sv =====
// Binary to decimal ASCII converter. Pulse start with a 27-bit unsigned value
// while busy is low and the block returns the decimal digits of that value as
// ASCII characters ('0'..'9'), most significant first, one character per clock,
// each marked by a one-cycle strobe; last is high on the units digit. Leading
// zeros are dropped, so zero gives the single character '0'. Values above the
// largest NUM_DIGITS-digit number (99,999,999 by default) are saturated to all
// nines and every character of that word carries overflow. The receiver cannot
// stall: characters come out as soon as they are ready and must be taken.
// A word passes a clamp stage and then one divide-by-ten stage per digit before
// it reaches the character serializer. A new word may be accepted every cycle
// while busy is low; the serializer sends each word as 1 to NUM_DIGITS
// characters (eight for a full-width value) and can take the next word while
// it sends the units digit of the current one. While the serializer is still
// sending, a finished word waits in the last pipeline stage and busy goes high,
// freezing the pipe.
module binary_to_decimal_ascii
	import bda_pkg::*;
#(
	parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [VALUE_W-1:0] value,
	output logic               strobe,
	output logic [CHAR_W-1:0]  char_code,
	output logic               last,
	output logic               overflow
);

	localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

	// Pipeline chain: position 0 is the clamp stage, position k+1 follows digit stage k
	bda_ctl_t                           ctl_c  [NUM_DIGITS+1];
	logic [VALUE_W-1:0]                 rest_c [NUM_DIGITS+1];
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digs_c [NUM_DIGITS+1];
	logic [IDX_W-1:0]                   msd_c  [NUM_DIGITS+1];

	logic adv;
	logic ser_rdy;
	logic ser_load;

	// Advance the whole pipe unless a finished word is waiting on the serializer
	assign adv      = !ctl_c[NUM_DIGITS].vld || ser_rdy;
	assign busy     = !adv;
	assign ser_load = ctl_c[NUM_DIGITS].vld && ser_rdy;

	bda_clamp #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_clamp (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.start (start),
		.value (value),
		.ctl_s1(ctl_c[0]),
		.val_s1(rest_c[0])
	);

	// The units digit is always sent, so the search starts at position zero
	assign digs_c[0] = '0;
	assign msd_c[0]  = '0;

	for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_digit
		bda_digit_stage #(
			.NUM_DIGITS(NUM_DIGITS),
			.IDX_W     (IDX_W),
			.K         (k)
		) u_stage (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.ctl_i (ctl_c[k]),
			.rest_i(rest_c[k]),
			.digs_i(digs_c[k]),
			.msd_i (msd_c[k]),
			.ctl_s (ctl_c[k+1]),
			.rest_s(rest_c[k+1]),
			.digs_s(digs_c[k+1]),
			.msd_s (msd_c[k+1])
		);
	end

	bda_serializer #(
		.NUM_DIGITS(NUM_DIGITS),
		.IDX_W     (IDX_W)
	) u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (ser_load),
		.ctl_i    (ctl_c[NUM_DIGITS]),
		.digs_i   (digs_c[NUM_DIGITS]),
		.msd_i    (msd_c[NUM_DIGITS]),
		.rdy      (ser_rdy),
		.strobe   (strobe),
		.char_code(char_code),
		.last     (last),
		.overflow (overflow)
	);

	// A run of characters continues until its units digit
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("character run broke off before its last character");

	// Overflow holds across one run
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> overflow == $past(overflow))
		else $error("overflow changed within a run");

	// Every character is a decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (char_code >= ASCII_ZERO) && (char_code <= ASCII_NINE))
		else $error("character is not a decimal digit");

	// A saturated word is all nines
	a_ovf_nines: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && overflow |-> char_code == ASCII_NINE)
		else $error("saturated word holds a digit other than nine");

endmodule
